@@ rtl/bilinear_pixel_interpolator_assert.svh @@
// ----------------------------------------------------------------------------
// bilinear pixel interpolator assertion macros
// concurrent checks clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BILINEAR_PIXEL_INTERPOLATOR_ASSERT_SVH
`define BILINEAR_PIXEL_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// plain property check
`define BPI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("bpi check failed");

// implication check
`define BPI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bpi check failed");

`else

`define BPI_ASSERT(lbl, prop)
`define BPI_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

@@ rtl/bpi_pkg.sv @@
// ----------------------------------------------------------------------------
// bpi_pkg
// shared constants and types of the bilinear pixel interpolator
// ----------------------------------------------------------------------------
package bpi_pkg;

	localparam int MAX_PIXELS = 262144;
	localparam int ADDR_W     = $clog2(MAX_PIXELS);
	localparam int FRAC_BITS  = 8;
	localparam int COORD_W    = 20;
	localparam int INT_W      = COORD_W - FRAC_BITS;
	localparam int DIM_W      = 13;
	localparam int PIX_W      = 8;
	localparam int OUT_W      = 16;
	localparam int PADDR_W    = 18;
	// weight is a product of two (FRAC_BITS+1)-bit factors
	localparam int WGT_W      = 2 * (FRAC_BITS + 1);
	localparam int PROD_W     = WGT_W + PIX_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int SHIFT      = 2 * FRAC_BITS - 8;
	localparam int MUL_W      = 2 * DIM_W;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// per-query control travelling alongside the memory read
	typedef struct packed {
		logic                 live;
		logic                 in_img;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
	} q_ctl_t;

endpackage

@@ rtl/bpi_mem.sv @@
// ----------------------------------------------------------------------------
// bpi_mem
// image byte store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module bpi_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [bpi_pkg::ADDR_W-1:0] waddr,
	input  logic [bpi_pkg::PIX_W-1:0]  wdata,
	input  logic [bpi_pkg::ADDR_W-1:0] raddr_a,
	input  logic [bpi_pkg::ADDR_W-1:0] raddr_b,
	output logic [bpi_pkg::PIX_W-1:0]  rdata_a,
	output logic [bpi_pkg::PIX_W-1:0]  rdata_b
);
	import bpi_pkg::*;

	logic [PIX_W-1:0] mem [MAX_PIXELS];
	logic [PIX_W-1:0] rd_a_q;
	logic [PIX_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read before write on a same-cycle collision
	always_ff @(posedge clk) begin
		rd_a_q <= mem[raddr_a];
		rd_b_q <= mem[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

@@ rtl/bpi_addr.sv @@
// ----------------------------------------------------------------------------
// bpi_addr
// bounds test, neighbour clamping and linear address generation
// ----------------------------------------------------------------------------
module bpi_addr (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        query,
	input  logic [bpi_pkg::COORD_W-1:0] x_coord,
	input  logic [bpi_pkg::COORD_W-1:0] y_coord,
	input  logic [bpi_pkg::DIM_W-1:0]   image_width,
	input  logic [bpi_pkg::DIM_W-1:0]   image_height,
	output logic [bpi_pkg::ADDR_W-1:0]  addr00,
	output logic [bpi_pkg::ADDR_W-1:0]  addr01,
	output logic [bpi_pkg::ADDR_W-1:0]  addr10,
	output logic [bpi_pkg::ADDR_W-1:0]  addr11,
	output bpi_pkg::q_ctl_t             ctl
);
	import bpi_pkg::*;

	logic [DIM_W-1:0]         wm1;
	logic [DIM_W-1:0]         hm1;
	logic                     in_img;
	logic [INT_W-1:0]         u0;
	logic [INT_W-1:0]         v0;
	logic [DIM_W-1:0]         u0p1;
	logic [DIM_W-1:0]         v0p1;
	logic [DIM_W-1:0]         u1;
	logic [DIM_W-1:0]         v1;

	q_ctl_t                   ctl_s1;
	logic [INT_W-1:0]         u0_s1;
	logic [DIM_W-1:0]         u1_s1;
	logic [DIM_W-1:0]         v0_s1;
	logic [DIM_W-1:0]         v1_s1;
	logic [MUL_W-1:0]         row0_prod;
	logic [MUL_W-1:0]         row1_prod;

	q_ctl_t                   ctl_s2;
	logic [INT_W-1:0]         u0_s2;
	logic [DIM_W-1:0]         u1_s2;
	logic [ADDR_W-1:0]        base0_s2;
	logic [ADDR_W-1:0]        base1_s2;

	assign wm1 = image_width - DIM_W'(1);
	assign hm1 = image_height - DIM_W'(1);

	// a zero dimension leaves nothing inside
	assign in_img = (image_width != '0) && (image_height != '0) &&
		({1'b0, x_coord} <= {wm1, {FRAC_BITS{1'b0}}}) &&
		({1'b0, y_coord} <= {hm1, {FRAC_BITS{1'b0}}});

	assign u0   = x_coord[COORD_W-1:FRAC_BITS];
	assign v0   = y_coord[COORD_W-1:FRAC_BITS];
	assign u0p1 = {1'b0, u0} + DIM_W'(1);
	assign v0p1 = {1'b0, v0} + DIM_W'(1);
	// last column or row: right or lower neighbour falls back onto itself
	assign u1   = (u0p1 < image_width)  ? u0p1 : {1'b0, u0};
	assign v1   = (v0p1 < image_height) ? v0p1 : {1'b0, v0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1.live   <= query;
			ctl_s1.in_img <= in_img;
			ctl_s1.fx     <= x_coord[FRAC_BITS-1:0];
			ctl_s1.fy     <= y_coord[FRAC_BITS-1:0];
			ctl_s2        <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		u0_s1 <= u0;
		u1_s1 <= u1;
		v0_s1 <= {1'b0, v0};
		v1_s1 <= v1;
	end

	assign row0_prod = MUL_W'(v0_s1) * MUL_W'(image_width);
	assign row1_prod = MUL_W'(v1_s1) * MUL_W'(image_width);

	// addresses wrap at the memory size
	always_ff @(posedge clk) begin
		u0_s2    <= u0_s1;
		u1_s2    <= u1_s1;
		base0_s2 <= row0_prod[ADDR_W-1:0];
		base1_s2 <= row1_prod[ADDR_W-1:0];
	end

	assign addr00 = base0_s2 + ADDR_W'(u0_s2);
	assign addr01 = base0_s2 + ADDR_W'(u1_s2);
	assign addr10 = base1_s2 + ADDR_W'(u0_s2);
	assign addr11 = base1_s2 + ADDR_W'(u1_s2);
	assign ctl    = ctl_s2;

endmodule

@@ rtl/bpi_blend.sv @@
// ----------------------------------------------------------------------------
// bpi_blend
// weight generation, weighted sum of four neighbours and rounding
// ----------------------------------------------------------------------------
module bpi_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bpi_pkg::q_ctl_t           ctl,
	input  logic [bpi_pkg::PIX_W-1:0] pix00,
	input  logic [bpi_pkg::PIX_W-1:0] pix01,
	input  logic [bpi_pkg::PIX_W-1:0] pix10,
	input  logic [bpi_pkg::PIX_W-1:0] pix11,
	output logic                      done,
	output logic                      valid_res,
	output logic [bpi_pkg::OUT_W-1:0] intensity
);
	import bpi_pkg::*;

	logic [FRAC_BITS:0]  omfx;
	logic [FRAC_BITS:0]  omfy;
	logic [FRAC_BITS:0]  fx_e;
	logic [FRAC_BITS:0]  fy_e;

	q_ctl_t              ctl_s3;
	logic [WGT_W-1:0]    w00_s3;
	logic [WGT_W-1:0]    w01_s3;
	logic [WGT_W-1:0]    w10_s3;
	logic [WGT_W-1:0]    w11_s3;

	q_ctl_t              ctl_s4;
	logic [PROD_W-1:0]   p00_s4;
	logic [PROD_W-1:0]   p01_s4;
	logic [PROD_W-1:0]   p10_s4;
	logic [PROD_W-1:0]   p11_s4;

	logic [SUM_W-1:0]    sum;
	logic [SUM_W-1:0]    rounded;

	logic                done_q;
	logic                valid_q;
	logic [OUT_W-1:0]    intensity_q;

	assign fx_e = {1'b0, ctl.fx};
	assign fy_e = {1'b0, ctl.fy};
	assign omfx = {1'b1, {FRAC_BITS{1'b0}}} - fx_e;
	assign omfy = {1'b1, {FRAC_BITS{1'b0}}} - fy_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			done_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			ctl_s3  <= ctl;
			ctl_s4  <= ctl_s3;
			done_q  <= ctl_s4.live;
			valid_q <= ctl_s4.live && ctl_s4.in_img;
		end
	end

	always_ff @(posedge clk) begin
		w00_s3 <= WGT_W'(omfx) * WGT_W'(omfy);
		w01_s3 <= WGT_W'(fx_e) * WGT_W'(omfy);
		w10_s3 <= WGT_W'(omfx) * WGT_W'(fy_e);
		w11_s3 <= WGT_W'(fx_e) * WGT_W'(fy_e);
	end

	always_ff @(posedge clk) begin
		p00_s4 <= PROD_W'(pix00) * PROD_W'(w00_s3);
		p01_s4 <= PROD_W'(pix01) * PROD_W'(w01_s3);
		p10_s4 <= PROD_W'(pix10) * PROD_W'(w10_s3);
		p11_s4 <= PROD_W'(pix11) * PROD_W'(w11_s3);
	end

	// round half up to eight fraction bits
	assign sum     = SUM_W'(p00_s4) + SUM_W'(p01_s4) + SUM_W'(p10_s4) + SUM_W'(p11_s4);
	assign rounded = sum + (SUM_W'(1) << (SHIFT - 1));

	always_ff @(posedge clk) begin
		if (ctl_s4.in_img) begin
			intensity_q <= rounded[SHIFT+OUT_W-1:SHIFT];
		end else begin
			intensity_q <= '0;
		end
	end

	assign done      = done_q;
	assign valid_res = valid_q;
	assign intensity = intensity_q;

endmodule

@@ rtl/bilinear_pixel_interpolator.sv @@
// ----------------------------------------------------------------------------
// bilinear_pixel_interpolator
// 8-bit grayscale image store with bilinear sampling at Q12.8 points
// ----------------------------------------------------------------------------
// One word is taken every clock cycle: busy is never raised, so start may be
// held high continuously. A pixel write gives no result and lands in the image
// store on the edge after the one that accepts it, so a query taken just before
// it still reads the old pixel and every later query sees the new one. A
// query gives its result from the last pipeline register: done is high for
// exactly one cycle with valid_res and intensity (unsigned Q8.8), and results
// cannot be held off by the receiver.
// The pipeline steps, in order, are the bounds test, row multiply, address add
// and store read, weighting multiply, then the sum and rounding. The image is
// kept in two copies, each with one write port and two read ports, so the
// upper and lower neighbour pairs are read in the same cycle. The store needs
// no clearing after reset; pixels must be written before they are sampled.
// Register 0 is the image width, register 1 the height; change them only
// while no query is in flight.
`include "bilinear_pixel_interpolator_assert.svh"

module bilinear_pixel_interpolator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          op,
	input  logic [bpi_pkg::PADDR_W-1:0]   pixel_addr,
	input  logic [bpi_pkg::PIX_W-1:0]     pixel_value,
	input  logic [bpi_pkg::COORD_W-1:0]   x_coord,
	input  logic [bpi_pkg::COORD_W-1:0]   y_coord,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [bpi_pkg::DIM_W-1:0]     cfg_data,
	output logic                          done,
	output logic                          valid_res,
	output logic [bpi_pkg::OUT_W-1:0]     intensity
);
	import bpi_pkg::*;

	logic              accept;
	logic              wr_en;
	logic              query;
	logic              wr_en_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic [PIX_W-1:0]  wdata_s1;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [ADDR_W-1:0] addr00;
	logic [ADDR_W-1:0] addr01;
	logic [ADDR_W-1:0] addr10;
	logic [ADDR_W-1:0] addr11;
	logic [PIX_W-1:0]  pix00;
	logic [PIX_W-1:0]  pix01;
	logic [PIX_W-1:0]  pix10;
	logic [PIX_W-1:0]  pix11;
	q_ctl_t            ctl;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign wr_en  = accept && !op;
	assign query  = accept && op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(512);
			height_q <= DIM_W'(512);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// a write lands on the edge where the query just ahead of it reads the store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= wr_en;
		end
	end

	always_ff @(posedge clk) begin
		waddr_s1 <= ADDR_W'(pixel_addr);
		wdata_s1 <= pixel_value;
	end

	bpi_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.query        (query),
		.x_coord      (x_coord),
		.y_coord      (y_coord),
		.image_width  (width_q),
		.image_height (height_q),
		.addr00       (addr00),
		.addr01       (addr01),
		.addr10       (addr10),
		.addr11       (addr11),
		.ctl          (ctl)
	);

	// upper neighbour pair
	bpi_mem u_mem_top (
		.clk     (clk),
		.we      (wr_en_s1),
		.waddr   (waddr_s1),
		.wdata   (wdata_s1),
		.raddr_a (addr00),
		.raddr_b (addr01),
		.rdata_a (pix00),
		.rdata_b (pix01)
	);

	// lower neighbour pair
	bpi_mem u_mem_bot (
		.clk     (clk),
		.we      (wr_en_s1),
		.waddr   (waddr_s1),
		.wdata   (wdata_s1),
		.raddr_a (addr10),
		.raddr_b (addr11),
		.rdata_a (pix10),
		.rdata_b (pix11)
	);

	bpi_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.pix00     (pix00),
		.pix01     (pix01),
		.pix10     (pix10),
		.pix11     (pix11),
		.done      (done),
		.valid_res (valid_res),
		.intensity (intensity)
	);

	`BPI_ASSERT(a_query_latency, done == $past(arst_n && start && !busy && op, 5))
	`BPI_ASSERT_IMP(a_valid_needs_done, valid_res, done)
	`BPI_ASSERT_IMP(a_outside_is_zero, done && !valid_res, intensity == '0)
	`BPI_ASSERT_IMP(a_result_range, valid_res, intensity <= OUT_W'(65280))

endmodule

@@ tb/sv/tb_bilinear_pixel_interpolator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_pixel_interpolator
// self-checking bench for the bilinear pixel interpolator: pixel writes and
// Q12.8 point queries go in through the start/busy port in random bursts.
// A software copy of the image and the size registers predicts each
// interpolated Q8.8 intensity. The monitor checks every done word against the
// oldest prediction. Queries only ever touch pixels that were written first.
// ----------------------------------------------------------------------------
module tb_bilinear_pixel_interpolator;
	import bpi_pkg::*;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam longint unsigned COORD_MAX = (64'd1 << COORD_W) - 1;
	localparam int ROUND_SH = 2 * FRAC_BITS - 8;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic               op;
		logic [PADDR_W-1:0] addr;
		logic [PIX_W-1:0]   value;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		bit                 hold;
	} pix_word_t;

	typedef struct {
		logic             valid;
		logic [OUT_W-1:0] level;
	} sample_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               op = OP_WRITE;
	logic [PADDR_W-1:0] pixel_addr = '0;
	logic [PIX_W-1:0]   pixel_value = '0;
	logic [COORD_W-1:0] x_coord = '0;
	logic [COORD_W-1:0] y_coord = '0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = REG_WIDTH;
	logic [DIM_W-1:0]   cfg_data = '0;
	logic               done;
	logic               valid_res;
	logic [OUT_W-1:0]   intensity;

	// image copy and size registers as the block should hold them
	bit [PIX_W-1:0]     image_copy [MAX_PIXELS];
	logic [DIM_W-1:0]   img_w = 13'd512;
	logic [DIM_W-1:0]   img_h = 13'd512;

	// pixels that some queued write will have stored before a query needs them
	bit                 planned_px [MAX_PIXELS];
	logic [ADDR_W-1:0]  near_addr [4];
	int unsigned        words_planned = 0;

	pix_word_t          pending_words [$];
	sample_t            expected_samples [$];
	pix_word_t          cur_word;
	sample_t            want;
	int                 burst_left = 0;
	int                 gap_left = 0;
	int                 idle_cycles = 0;
	int                 fail_count = 0;

	bilinear_pixel_interpolator uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.pixel_addr(pixel_addr),
		.pixel_value(pixel_value),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.valid_res(valid_res),
		.intensity(intensity)
	);

	always #2 clk = ~clk;

	function automatic bit inside_image(input logic [COORD_W-1:0] x, y);
		longint unsigned w, h;
		w = img_w;
		h = img_h;
		if (w == 0 || h == 0)
			return 1'b0;
		return (x <= ((w - 1) << FRAC_BITS)) && (y <= ((h - 1) << FRAC_BITS));
	endfunction

	// k bit 0 selects the right neighbour, bit 1 the lower one; both clamp at the edge
	function automatic logic [ADDR_W-1:0] corner_addr(input logic [COORD_W-1:0] x, y,
			input int k);
		longint unsigned col, row;
		col = x >> FRAC_BITS;
		row = y >> FRAC_BITS;
		if (k[0] && col + 1 < img_w)
			col++;
		if (k[1] && row + 1 < img_h)
			row++;
		return ADDR_W'((row * img_w + col) % MAX_PIXELS);
	endfunction

	function automatic sample_t blend(input logic [COORD_W-1:0] x, y);
		sample_t r;
		longint unsigned one, fx, fy, acc;
		r.valid = 1'b0;
		r.level = '0;
		if (!inside_image(x, y))
			return r;
		one = 64'd1 << FRAC_BITS;
		fx = x & (one - 1);
		fy = y & (one - 1);
		acc = image_copy[corner_addr(x, y, 0)] * (one - fx) * (one - fy)
			+ image_copy[corner_addr(x, y, 1)] * fx * (one - fy)
			+ image_copy[corner_addr(x, y, 2)] * (one - fx) * fy
			+ image_copy[corner_addr(x, y, 3)] * fx * fy;
		// round half up to eight fraction bits
		acc = (acc + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
		if (acc > 65280)
			acc = 65280;
		r.valid = 1'b1;
		r.level = acc[OUT_W-1:0];
		return r;
	endfunction

	function automatic void take_word(input pix_word_t w);
		if (w.op == OP_WRITE) begin
			if (w.addr < MAX_PIXELS)
				image_copy[w.addr] = w.value;
		end else begin
			expected_samples.push_back(blend(w.x, w.y));
		end
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic void plan_write(input logic [PADDR_W-1:0] a, input logic [PIX_W-1:0] v);
		pix_word_t w;
		w.op = OP_WRITE;
		w.addr = a;
		w.value = v;
		w.x = COORD_W'($urandom);
		w.y = COORD_W'($urandom);
		w.hold = 1'b0;
		planned_px[a] = 1'b1;
		pending_words.push_back(w);
		words_planned++;
	endfunction

	function automatic void plan_query(input logic [COORD_W-1:0] x, y, input bit hold);
		pix_word_t w;
		int k;
		// fill any neighbour not yet written so no stale pixel is ever sampled
		if (inside_image(x, y)) begin
			for (k = 0; k < 4; k++) begin
				near_addr[k] = corner_addr(x, y, k);
				if (!planned_px[near_addr[k]])
					plan_write(near_addr[k], rand_pixel());
			end
		end
		w.op = OP_QUERY;
		w.addr = PADDR_W'($urandom);
		w.value = PIX_W'($urandom);
		w.x = x;
		w.y = y;
		w.hold = hold;
		pending_words.push_back(w);
		words_planned++;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input longint unsigned lim);
		longint unsigned span, v;
		span = (lim > COORD_MAX) ? COORD_MAX : lim;
		case ($urandom_range(0, 11))
			0: v = $urandom & COORD_MAX;
			1: v = lim + 1 + $urandom_range(0, 3);
			2: v = span;
			3: v = longint'($urandom_range(0, span >> FRAC_BITS)) << FRAC_BITS;
			4: v = (longint'($urandom_range(0, span >> FRAC_BITS)) << FRAC_BITS) | 8'hFF;
			default: v = $urandom_range(0, span);
		endcase
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_W-1:0];
	endfunction

	function automatic void plan_rand_query();
		longint unsigned lim_x, lim_y;
		lim_x = (img_w == 0) ? 0 : (longint'(img_w) - 1) << FRAC_BITS;
		lim_y = (img_h == 0) ? 0 : (longint'(img_h) - 1) << FRAC_BITS;
		plan_query(pick_coord(lim_x), pick_coord(lim_y), $urandom_range(0, 49) == 0);
	endfunction

	function automatic void plan_rand_write();
		longint unsigned area;
		logic [PADDR_W-1:0] a;
		area = longint'(img_w) * img_h;
		if (area > MAX_PIXELS)
			area = MAX_PIXELS;
		case ($urandom_range(0, 2))
			// overwrite a pixel the last query is still reading
			0: a = near_addr[$urandom_range(0, 3)];
			1: a = (area == 0) ? PADDR_W'($urandom) :
				PADDR_W'($urandom_range(0, area - 1));
			default: a = PADDR_W'($urandom);
		endcase
		plan_write(a, rand_pixel());
	endfunction

	task automatic settle();
		while (pending_words.size() != 0 || start || expected_samples.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [DIM_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WIDTH)
			img_w = val;
		else
			img_h = val;
	endtask

	task automatic run_phase(input logic [DIM_W-1:0] w, h, input int n_words);
		int unsigned stop_at;
		settle();
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		stop_at = words_planned + n_words;
		while (words_planned < stop_at) begin
			if ($urandom_range(0, 99) < 65)
				plan_rand_query();
			else
				plan_rand_write();
		end
	endtask

	// driver: one word per accepted edge, bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			op <= OP_WRITE;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (start && !busy)
				take_word(cur_word);
			if (start && busy) begin
				// word held until taken
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_words.size() == 0 ||
					(pending_words[0].hold && expected_samples.size() != 0)) begin
				start <= 1'b0;
			end else begin
				cur_word = pending_words.pop_front();
				start <= 1'b1;
				op <= cur_word.op;
				pixel_addr <= cur_word.addr;
				pixel_value <= cur_word.value;
				x_coord <= cur_word.x;
				y_coord <= cur_word.y;
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 3) == 0) ?
						$urandom_range(50, 150) : $urandom_range(1, 12);
				burst_left--;
				if (burst_left == 0)
					gap_left = $urandom_range(0, 7);
			end
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (expected_samples.size() == 0) begin
					$error("result with nothing expected: valid_res %0d intensity %0d",
						valid_res, intensity);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (valid_res !== want.valid) begin
						$error("valid_res mismatch: expected %0d, actual %0d",
							want.valid, valid_res);
						fail_count++;
					end
					if (intensity !== want.level) begin
						$error("intensity mismatch: expected %0d, actual %0d",
							want.level, intensity);
						fail_count++;
					end
				end
			end
			if (done || (start && !busy) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		// directed words at the reset size of 512 x 512
		plan_write(18'd0, 8'hFF);
		plan_write(18'd1, 8'h00);
		plan_write(18'd512, 8'h80);
		plan_write(18'd513, 8'h7F);
		plan_query(20'h00000, 20'h00000, 1'b0);
		plan_query(20'h00080, 20'h00080, 1'b0);
		plan_query(20'h000FF, 20'h000FF, 1'b0);
		plan_query(20'h00040, 20'h00000, 1'b0);
		plan_write(18'd2, 8'hFF);
		plan_write(18'd3, 8'hFF);
		plan_write(18'd514, 8'hFF);
		plan_write(18'd515, 8'hFF);
		// all four neighbours full scale with the largest fractions
		plan_query(20'h002FF, 20'h000FF, 1'b0);
		plan_query(20'd511 << 8, 20'd511 << 8, 1'b0);
		plan_query(20'd511 << 8, (20'd200 << 8) | 20'h33, 1'b0);
		plan_query((20'd100 << 8) | 20'hC0, 20'd511 << 8, 1'b0);
		plan_query((20'd511 << 8) + 20'd1, 20'h00000, 1'b0);
		plan_query(20'h00000, (20'd511 << 8) + 20'd1, 1'b0);
		// pause until the pipe is empty
		plan_query(20'hFFFFF, 20'hFFFFF, 1'b1);
		plan_write(18'h3FFFF, 8'hA5);
		plan_query(20'h00000, 20'h00000, 1'b0);
		plan_write(18'd0, 8'h11);
		plan_query(20'h00000, 20'h00000, 1'b0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		run_phase(13'd16, 13'd12, 70);
		run_phase(13'd2, 13'd2, 50);
		run_phase(13'd4096, 13'd4096, 70);
		run_phase(13'd8191, 13'd8191, 50);
		run_phase(13'd1, 13'd6, 40);
		run_phase(13'd5, 13'd1, 40);
		run_phase(13'd0, 13'd9, 25);
		run_phase(13'd10, 13'd0, 25);
		run_phase(DIM_W'($urandom_range(2, 40)), DIM_W'($urandom_range(2, 40)), 70);
		run_phase(DIM_W'($urandom_range(2, 4096)), DIM_W'($urandom_range(2, 4096)), 70);
		run_phase(DIM_W'($urandom_range(2, 64)), DIM_W'($urandom_range(2, 64)), 70);
		settle();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bpi_pkg.sv
rtl/bpi_mem.sv
rtl/bpi_addr.sv
rtl/bpi_blend.sv
rtl/bilinear_pixel_interpolator.sv
tb/sv/tb_bilinear_pixel_interpolator.sv
